@@ src/ibmw_pkg.sv @@
// ibmw_pkg: shared constants, mode codes and beat structs for the inode block map walker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ibmw_pkg;

   // Field widths, fixed by the port list
   localparam int MODE_W   = 2;
   localparam int SLOT_W   = 4;
   localparam int BLOCK_W  = 32;
   localparam int OFFSET_W = 48;
   localparam int IDX_W    = 9;
   localparam int LEVEL_W  = 2;

   // Inode layout
   localparam int DIRECT_POINTERS_DEF = 12;
   localparam int PTR_BITS            = 9;                 // log2 of pointers per block
   localparam int POINTERS_PER_BLOCK  = 1 << PTR_BITS;
   localparam int BLOCK_SHIFT         = 12;                // log2 of block bytes
   localparam int BLOCK_BYTES         = 1 << BLOCK_SHIFT;

   // Offset still to walk below a double or triple root
   localparam int REM_W = 2 * PTR_BITS;

   // Block counts of the indirect regions
   localparam logic [OFFSET_W-1:0] SPAN_1 = OFFSET_W'(POINTERS_PER_BLOCK);
   localparam logic [OFFSET_W-1:0] SPAN_2 = OFFSET_W'(1) << (2 * PTR_BITS);
   localparam logic [OFFSET_W-1:0] SPAN_3 = OFFSET_W'(1) << (3 * PTR_BITS);

   // Walk depth codes
   localparam logic [LEVEL_W-1:0] LEVEL_IDLE   = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE    = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO    = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE  = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD     = 2'd0,
      MODE_LOOKUP   = 2'd1,
      MODE_RESPONSE = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [SLOT_W-1:0]     slot;
      logic [BLOCK_W-1:0]    pointer_value;
      logic [OFFSET_W-1:0]   offset;
      logic                  offset_in_bytes;
      logic                  read_failed;
   } req_type;

   typedef struct packed {
      logic                  is_request;
      logic [BLOCK_W-1:0]    read_block;
      logic [IDX_W-1:0]      entry_index;
      logic [BLOCK_W-1:0]    block_number;
      logic                  error;
   } rsp_type;

endpackage

@@ src/ibmw_front.sv @@
// ibmw_front: input register; captures one request beat per cycle while accept is high.
// Depends on ibmw_pkg.
`timescale 1ns / 1ps

module ibmw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ibmw_pkg::req_type req,
   output logic              valid,
   output ibmw_pkg::req_type req_q
);
   import ibmw_pkg::*;

   logic    valid_ff;
   req_type req_ff;

   // Beat flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   assign valid = valid_ff;
   assign req_q = req_ff;

endmodule

@@ src/ibmw_core.sv @@
// ibmw_core: pointer store, walk state and the single-pass lookup logic with its result register.
// Depends on ibmw_pkg; fed by ibmw_front.
`timescale 1ns / 1ps

module ibmw_core #(
   parameter int DIRECT_POINTERS = ibmw_pkg::DIRECT_POINTERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid,
   input  ibmw_pkg::req_type req,
   output logic              rsp_valid,
   output ibmw_pkg::rsp_type rsp
);
   import ibmw_pkg::*;

   localparam int DIR_IDX_W = (DIRECT_POINTERS > 1) ? $clog2(DIRECT_POINTERS) : 1;

   // Region bounds in blocks
   localparam logic [OFFSET_W-1:0] BOUND_D = OFFSET_W'(DIRECT_POINTERS);
   localparam logic [OFFSET_W-1:0] BOUND_1 = BOUND_D + SPAN_1;
   localparam logic [OFFSET_W-1:0] BOUND_2 = BOUND_1 + SPAN_2;
   localparam logic [OFFSET_W-1:0] BOUND_3 = BOUND_2 + SPAN_3;

   // Slot codes of the roots
   localparam logic [SLOT_W:0] SLOT_SINGLE = (SLOT_W + 1)'(DIRECT_POINTERS);
   localparam logic [SLOT_W:0] SLOT_DOUBLE = (SLOT_W + 1)'(DIRECT_POINTERS + 1);
   localparam logic [SLOT_W:0] SLOT_TRIPLE = (SLOT_W + 1)'(DIRECT_POINTERS + 2);

   logic [BLOCK_W-1:0] direct_ff [DIRECT_POINTERS];
   logic [BLOCK_W-1:0] single_ff;
   logic [BLOCK_W-1:0] double_ff;
   logic [BLOCK_W-1:0] triple_ff;

   logic [LEVEL_W-1:0] levels_ff;
   logic [LEVEL_W-1:0] levels_in;
   logic [REM_W-1:0]   rem_ff;
   logic [REM_W-1:0]   rem_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [OFFSET_W-1:0] blk;
   logic [OFFSET_W-1:0] rel_2;
   logic [OFFSET_W-1:0] rel_3;
   logic [SLOT_W:0]     slot_x;

   // Block offset and offsets within the double and triple regions
   assign blk    = req.offset_in_bytes ? (req.offset >> BLOCK_SHIFT) : req.offset;
   assign rel_2  = blk - BOUND_1;
   assign rel_3  = blk - BOUND_2;
   assign slot_x = {1'b0, req.slot};

   // Pointer loads
   always_ff @(posedge clock) begin
      if (valid && req.mode == MODE_LOAD) begin
         if (slot_x < SLOT_SINGLE) begin
            direct_ff[req.slot[DIR_IDX_W-1:0]] <= req.pointer_value;
         end else if (slot_x == SLOT_SINGLE) begin
            single_ff <= req.pointer_value;
         end else if (slot_x == SLOT_DOUBLE) begin
            double_ff <= req.pointer_value;
         end else if (slot_x == SLOT_TRIPLE) begin
            triple_ff <= req.pointer_value;
         end
      end
   end

   // Lookup and walk step
   always_comb begin
      levels_in    = levels_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (valid) begin
         case (req.mode)
            MODE_LOOKUP: begin
               rsp_valid_in = 1'b1;
               levels_in    = LEVEL_IDLE;
               rem_in       = '0;
               if (blk >= BOUND_3) begin
                  rsp_in.error = 1'b1;
               end else if (blk < BOUND_D) begin
                  rsp_in.block_number = direct_ff[blk[DIR_IDX_W-1:0]];
               end else if (blk < BOUND_1) begin
                  levels_in          = LEVEL_ONE;
                  rsp_in.is_request  = 1'b1;
                  rsp_in.read_block  = single_ff;
                  rsp_in.entry_index = IDX_W'(blk - BOUND_D);
               end else if (blk < BOUND_2) begin
                  levels_in          = LEVEL_TWO;
                  rem_in             = REM_W'(rel_2[PTR_BITS-1:0]);
                  rsp_in.is_request  = 1'b1;
                  rsp_in.read_block  = double_ff;
                  rsp_in.entry_index = IDX_W'(rel_2[2*PTR_BITS-1:PTR_BITS]);
               end else begin
                  levels_in          = LEVEL_THREE;
                  rem_in             = rel_3[REM_W-1:0];
                  rsp_in.is_request  = 1'b1;
                  rsp_in.read_block  = triple_ff;
                  rsp_in.entry_index = IDX_W'(rel_3[3*PTR_BITS-1:2*PTR_BITS]);
               end
            end
            MODE_RESPONSE: begin
               if (levels_ff != LEVEL_IDLE) begin
                  rsp_valid_in = 1'b1;
                  if (req.read_failed) begin
                     levels_in    = LEVEL_IDLE;
                     rem_in       = '0;
                     rsp_in.error = 1'b1;
                  end else begin
                     levels_in = levels_ff - LEVEL_ONE;
                     if (levels_ff == LEVEL_ONE) begin
                        rem_in              = '0;
                        rsp_in.block_number = req.pointer_value;
                     end else if (levels_ff == LEVEL_THREE) begin
                        rem_in             = REM_W'(rem_ff[PTR_BITS-1:0]);
                        rsp_in.is_request  = 1'b1;
                        rsp_in.read_block  = req.pointer_value;
                        rsp_in.entry_index = IDX_W'(rem_ff[2*PTR_BITS-1:PTR_BITS]);
                     end else begin
                        rsp_in.is_request  = 1'b1;
                        rsp_in.read_block  = req.pointer_value;
                        rsp_in.entry_index = IDX_W'(rem_ff[PTR_BITS-1:0]);
                     end
                  end
               end
            end
            default: begin
               // loads give no result; the unused mode is dropped
            end
         endcase
      end
   end

   // Walk state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff    <= LEVEL_IDLE;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         levels_ff    <= levels_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ src/inode_block_map_walker.sv @@
// inode_block_map_walker: top level; input register feeding the lookup core.
// Depends on ibmw_pkg, ibmw_front and ibmw_core.
//
//   channel  ports            handshake
//   request  req_*            beat taken at an edge with start high and busy low
//   result   rsp_*            one cycle wide, marked by rsp_strobe
//
// One beat is taken every cycle that start is high and busy low; busy is high through
// reset and at the first edge with reset low, which thus takes no beat.
// A request beat is held in the input register, then passes through the lookup
// logic into the result register, from which its result is driven.
// Reset is synchronous and clears the walk state and strobes; the pointer
// store holds nothing defined until loaded. The receiver cannot stall.
`timescale 1ns / 1ps

module inode_block_map_walker #(
   parameter int DIRECT_POINTERS = ibmw_pkg::DIRECT_POINTERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ibmw_pkg::MODE_W-1:0]   req_mode,
   input  logic [ibmw_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ibmw_pkg::BLOCK_W-1:0]  req_pointer_value,
   input  logic [ibmw_pkg::OFFSET_W-1:0] req_offset,
   input  logic                          req_offset_in_bytes,
   input  logic                          req_read_failed,
   output logic                          rsp_strobe,
   output logic                          rsp_is_request,
   output logic [ibmw_pkg::BLOCK_W-1:0]  rsp_read_block,
   output logic [ibmw_pkg::IDX_W-1:0]    rsp_entry_index,
   output logic [ibmw_pkg::BLOCK_W-1:0]  rsp_block_number,
   output logic                          rsp_error
);
   import ibmw_pkg::*;

   logic    busy_ff;
   logic    accept;
   req_type req_in;
   req_type req_q;
   logic    req_valid;
   rsp_type rsp;

   // Held off while the registered copy of reset is high
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   assign req_in = '{mode:            mode_type'(req_mode),
                     slot:            req_slot,
                     pointer_value:   req_pointer_value,
                     offset:          req_offset,
                     offset_in_bytes: req_offset_in_bytes,
                     read_failed:     req_read_failed};

   ibmw_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_in),
      .valid (req_valid),
      .req_q (req_q)
   );

   ibmw_core #(
      .DIRECT_POINTERS(DIRECT_POINTERS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .valid    (req_valid),
      .req      (req_q),
      .rsp_valid(rsp_strobe),
      .rsp      (rsp)
   );

   assign rsp_is_request   = rsp.is_request;
   assign rsp_read_block   = rsp.read_block;
   assign rsp_entry_index  = rsp.entry_index;
   assign rsp_block_number = rsp.block_number;
   assign rsp_error        = rsp.error;

endmodule

@@ verif/tb.sv @@
// tb: self-checking testbench for the inode block map walker, with a scoreboard class
// that predicts every answer beat. Depends on ibmw_pkg and inode_block_map_walker.
`timescale 1ns / 1ps

module tb;
   import ibmw_pkg::*;

   // Address space of the inode, in blocks
   localparam longint unsigned DP             = DIRECT_POINTERS_DEF;
   localparam longint unsigned PP             = POINTERS_PER_BLOCK;
   localparam longint unsigned PP2            = PP * PP;
   localparam longint unsigned FIRST_SINGLE   = DP;
   localparam longint unsigned FIRST_DOUBLE   = DP + PP;
   localparam longint unsigned FIRST_TRIPLE   = DP + PP + PP2;
   localparam longint unsigned BLOCK_LIMIT    = FIRST_TRIPLE + PP2 * PP;
   localparam longint unsigned MAX_BLOCK      = (64'd1 << OFFSET_W) - 1;
   localparam longint unsigned MAX_BYTE_BLOCK = (64'd1 << (OFFSET_W - BLOCK_SHIFT)) - 1;
   localparam int              TARGET_BEATS   = 1350;

   // Tracks the inode pointers and the walk in progress; predicts and checks answers
   class block_map_tracker;
      logic [BLOCK_W-1:0] direct_ptr [DIRECT_POINTERS_DEF];
      logic [BLOCK_W-1:0] single_root, double_root, triple_root;
      logic [LEVEL_W-1:0] depth_left = LEVEL_IDLE;
      longint unsigned    offset_left = 0;
      rsp_type            expected_answers[$];
      int                 mismatches = 0;
      int                 n_lookups = 0, n_responses = 0, n_loads = 0;
      int                 n_requests = 0, n_finals = 0, n_errors = 0;

      function void note_beat(req_type beat);
         rsp_type         ans;
         bit              has_ans;
         longint unsigned blk;
         longint unsigned rel;
         ans = '0;
         has_ans = 0;
         case (beat.mode)
            MODE_LOAD: begin
               n_loads++;
               if (beat.slot < DP) direct_ptr[beat.slot] = beat.pointer_value;
               else if (beat.slot == DP) single_root = beat.pointer_value;
               else if (beat.slot == DP + 1) double_root = beat.pointer_value;
               else if (beat.slot == DP + 2) triple_root = beat.pointer_value;
            end
            MODE_LOOKUP: begin
               n_lookups++;
               has_ans = 1;
               blk = beat.offset_in_bytes ? beat.offset / BLOCK_BYTES : beat.offset;
               depth_left = LEVEL_IDLE;
               offset_left = 0;
               if (blk >= BLOCK_LIMIT) begin
                  ans.error = 1'b1;
               end else if (blk < FIRST_SINGLE) begin
                  ans.block_number = direct_ptr[int'(blk)];
               end else if (blk < FIRST_DOUBLE) begin
                  depth_left = LEVEL_ONE;
                  ans.is_request = 1'b1;
                  ans.read_block = single_root;
                  ans.entry_index = IDX_W'(blk - FIRST_SINGLE);
               end else if (blk < FIRST_TRIPLE) begin
                  rel = blk - FIRST_DOUBLE;
                  depth_left = LEVEL_TWO;
                  offset_left = rel % PP;
                  ans.is_request = 1'b1;
                  ans.read_block = double_root;
                  ans.entry_index = IDX_W'(rel / PP);
               end else begin
                  rel = blk - FIRST_TRIPLE;
                  depth_left = LEVEL_THREE;
                  offset_left = rel % PP2;
                  ans.is_request = 1'b1;
                  ans.read_block = triple_root;
                  ans.entry_index = IDX_W'(rel / PP2);
               end
            end
            MODE_RESPONSE: begin
               // a response with no walk pending is dropped
               if (depth_left != LEVEL_IDLE) begin
                  n_responses++;
                  has_ans = 1;
                  if (beat.read_failed) begin
                     depth_left = LEVEL_IDLE;
                     offset_left = 0;
                     ans.error = 1'b1;
                  end else begin
                     depth_left = depth_left - 1'b1;
                     if (depth_left == LEVEL_IDLE) begin
                        offset_left = 0;
                        ans.block_number = beat.pointer_value;
                     end else begin
                        ans.is_request = 1'b1;
                        ans.read_block = beat.pointer_value;
                        if (depth_left == LEVEL_TWO) begin
                           ans.entry_index = IDX_W'(offset_left / PP);
                           offset_left = offset_left % PP;
                        end else begin
                           ans.entry_index = IDX_W'(offset_left % PP);
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
         if (has_ans) expected_answers.push_back(ans);
      endfunction

      function void check_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
         end
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (expected_answers.size() == 0) begin
            mismatches++;
            $display("%0t ns: answer beat with none expected, got 0x%0h", $time, got);
            return;
         end
         want = expected_answers.pop_front();
         if (want.error) n_errors++;
         else if (want.is_request) n_requests++;
         else n_finals++;
         check_field("is_request", want.is_request, got.is_request);
         check_field("read_block", want.read_block, got.read_block);
         check_field("entry_index", want.entry_index, got.entry_index);
         check_field("block_number", want.block_number, got.block_number);
         check_field("error", want.error, got.error);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [MODE_W-1:0]   req_mode;
   logic [SLOT_W-1:0]   req_slot;
   logic [BLOCK_W-1:0]  req_pointer_value;
   logic [OFFSET_W-1:0] req_offset;
   logic                req_offset_in_bytes;
   logic                req_read_failed;
   logic                rsp_strobe;
   logic                rsp_is_request;
   logic [BLOCK_W-1:0]  rsp_read_block;
   logic [IDX_W-1:0]    rsp_entry_index;
   logic [BLOCK_W-1:0]  rsp_block_number;
   logic                rsp_error;

   block_map_tracker tracker;
   bit               quiet;
   int               beats_done;
   req_type          seen_beat;
   rsp_type          seen_answer;

   inode_block_map_walker i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_slot            (req_slot),
      .req_pointer_value   (req_pointer_value),
      .req_offset          (req_offset),
      .req_offset_in_bytes (req_offset_in_bytes),
      .req_read_failed     (req_read_failed),
      .rsp_strobe          (rsp_strobe),
      .rsp_is_request      (rsp_is_request),
      .rsp_read_block      (rsp_read_block),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_block_number    (rsp_block_number),
      .rsp_error           (rsp_error)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both channels at the rising edge; older answers are checked first
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            seen_answer.is_request   = rsp_is_request;
            seen_answer.read_block   = rsp_read_block;
            seen_answer.entry_index  = rsp_entry_index;
            seen_answer.block_number = rsp_block_number;
            seen_answer.error        = rsp_error;
            tracker.check_answer(seen_answer);
         end
         if (start && !busy) begin
            seen_beat.mode            = mode_type'(req_mode);
            seen_beat.slot            = req_slot;
            seen_beat.pointer_value   = req_pointer_value;
            seen_beat.offset          = req_offset;
            seen_beat.offset_in_bytes = req_offset_in_bytes;
            seen_beat.read_failed     = req_read_failed;
            tracker.note_beat(seen_beat);
         end
      end
   end

   function automatic longint unsigned rand_between(longint unsigned lo, longint unsigned hi);
      longint unsigned r;
      r = {32'($urandom), 32'($urandom)};
      return lo + r % (hi - lo + 1);
   endfunction

   function automatic logic [OFFSET_W-1:0] rand_offset();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // Number of read responses a walk to this block needs
   function automatic int walk_depth(longint unsigned blk);
      if (blk >= BLOCK_LIMIT || blk < FIRST_SINGLE) return 0;
      if (blk < FIRST_DOUBLE) return 1;
      if (blk < FIRST_TRIPLE) return 2;
      return 3;
   endfunction

   // Mostly back to back, sometimes short gaps, now and then a long one
   task automatic idle_gap();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) n = 0;
      else if (r < 92) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   task automatic send_beat(mode_type mode, logic [SLOT_W-1:0] slot,
                            logic [BLOCK_W-1:0] value, logic [OFFSET_W-1:0] offset,
                            logic bytes, logic failed);
      idle_gap();
      @(negedge clock);
      start               = 1'b1;
      req_mode            = mode;
      req_slot            = slot;
      req_pointer_value   = value;
      req_offset          = offset;
      req_offset_in_bytes = bytes;
      req_read_failed     = failed;
      do @(posedge clock); while (busy);
   endtask

   // Lookup of a block, given as a block or a byte offset; unused fields carry junk
   task automatic lookup(longint unsigned blk, bit bytes);
      logic [OFFSET_W-1:0] off;
      if (bytes) off = OFFSET_W'((blk << BLOCK_SHIFT) | $urandom_range(0, BLOCK_BYTES - 1));
      else off = OFFSET_W'(blk);
      send_beat(MODE_LOOKUP, SLOT_W'($urandom_range(0, 15)), $urandom, off, bytes,
                1'($urandom_range(0, 1)));
   endtask

   task automatic respond(logic [BLOCK_W-1:0] value, logic failed);
      send_beat(MODE_RESPONSE, SLOT_W'($urandom_range(0, 15)), value, rand_offset(),
                1'($urandom_range(0, 1)), failed);
   endtask

   function automatic logic [BLOCK_W-1:0] rand_pointer();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   function automatic longint unsigned pick_block(bit bytes);
      case ($urandom_range(0, 9))
         0, 1: return rand_between(0, FIRST_SINGLE - 1);
         2, 3: return rand_between(FIRST_SINGLE, FIRST_DOUBLE - 1);
         4, 5: return rand_between(FIRST_DOUBLE, FIRST_TRIPLE - 1);
         6, 7: return rand_between(FIRST_TRIPLE, BLOCK_LIMIT - 1);
         8:    return rand_between(BLOCK_LIMIT, bytes ? MAX_BYTE_BLOCK : MAX_BLOCK);
         default: begin
            // region boundaries
            case ($urandom_range(0, 8))
               0: return 0;
               1: return FIRST_SINGLE - 1;
               2: return FIRST_SINGLE;
               3: return FIRST_DOUBLE - 1;
               4: return FIRST_DOUBLE;
               5: return FIRST_TRIPLE - 1;
               6: return FIRST_TRIPLE;
               7: return BLOCK_LIMIT - 1;
               default: return BLOCK_LIMIT;
            endcase
         end
      endcase
   endfunction

   // One walk with random pointers; some fail a read, some are cut short
   task automatic walk_path();
      longint unsigned blk;
      bit              bytes;
      int              r;
      bytes = 1'($urandom_range(0, 1));
      blk = pick_block(bytes);
      lookup(blk, bytes);
      beats_done++;
      for (int lvl = 0; lvl < walk_depth(blk); lvl++) begin
         r = $urandom_range(0, 99);
         if (r < 4) return;
         beats_done++;
         if (r < 9) begin
            respond($urandom, 1'b1);
            return;
         end
         respond(rand_pointer(), 1'b0);
      end
   endtask

   initial begin
      tracker             = new();
      quiet               = 1'b0;
      beats_done          = 0;
      reset               = 1'b1;
      start               = 1'b0;
      req_mode            = MODE_LOAD;
      req_slot            = '0;
      req_pointer_value   = '0;
      req_offset          = '0;
      req_offset_in_bytes = 1'b0;
      req_read_failed     = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill the inode first so no lookup ever sees an unloaded pointer
      for (int s = 0; s < DP + 3; s++)
         send_beat(MODE_LOAD, SLOT_W'(s), (s == 0) ? '0 : (s == DP - 1) ? '1 : $urandom,
                   rand_offset(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // slot past the roots: no effect
      send_beat(MODE_LOAD, '1, '1, '1, 1'b1, 1'b1);

      // Directed: direct edges, every indirect level, range limit, failures, noise
      lookup(0, 0);
      lookup(FIRST_SINGLE - 1, 1);
      lookup(FIRST_SINGLE, 0);
      respond('0, 1'b0);
      lookup(FIRST_DOUBLE - 1, 1);
      respond('1, 1'b1);
      lookup(FIRST_DOUBLE, 0);
      respond(32'h0000_0001, 1'b0);
      respond(32'h8000_0000, 1'b0);
      lookup(BLOCK_LIMIT - 1, 0);
      respond('1, 1'b0);
      respond(32'h5a5a_a5a5, 1'b0);
      respond('1, 1'b0);
      lookup(BLOCK_LIMIT, 0);
      send_beat(MODE_LOOKUP, '0, '0, '1, 1'b1, 1'b0);
      respond(32'h1234_5678, 1'b0);
      send_beat(MODE_NONE, '1, '1, '1, 1'b1, 1'b1);
      // a new lookup abandons the walk in flight
      lookup(FIRST_TRIPLE, 1);
      lookup(DP / 2, 0);
      respond('1, 1'b0);

      // Random traffic, mostly well-formed walks
      while (beats_done < TARGET_BEATS) begin
         int r;
         int s;
         if ($urandom_range(0, 99) < 3) quiet = !quiet;
         r = $urandom_range(0, 99);
         if (r < 6) begin
            s = $urandom_range(0, 15);
            send_beat(MODE_LOAD, SLOT_W'(s), rand_pointer(), rand_offset(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (s < DP + 3) beats_done++;
         end else if (r < 9) begin
            send_beat((r < 8) ? MODE_NONE : MODE_RESPONSE, SLOT_W'($urandom_range(0, 15)),
                      $urandom, rand_offset(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            walk_path();
         end
      end
      @(negedge clock);
      start = 1'b0;

      // Drain: answers trail their beat through the input and result registers
      while (tracker.expected_answers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Covered %0d lookups, %0d read responses and %0d pointer loads;",
               tracker.n_lookups, tracker.n_responses, tracker.n_loads);
      $display("checked %0d read requests, %0d final answers and %0d error answers.",
               tracker.n_requests, tracker.n_finals, tracker.n_errors);
      if (tracker.mismatches == 0 && tracker.expected_answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("Timeout: run did not complete");
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
